>>> rtl/image_rotate_nearest_macros.svh
`ifndef IMAGE_ROTATE_NEAREST_MACROS_SVH
`define IMAGE_ROTATE_NEAREST_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define IRN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define IRN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/irn_pkg.sv
`default_nettype none

package irn_pkg;

  // Frame store geometry
  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int DEPTH    = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W   = $clog2(DEPTH);

  // Field and register widths
  localparam int COORD_W  = 8;
  localparam int CNT_W    = 9;
  localparam int COEF_W   = 16;
  localparam int CFG_W    = 16;
  localparam int PIX_W    = 24;

  // Mapping arithmetic: offsets, products, sums, rounded source position
  localparam int FRAC     = 14;
  localparam int OFS_W    = COORD_W + 2;
  localparam int PROD_W   = OFS_W + COEF_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int SRC_W    = SUM_W - FRAC + 2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_COS  = 2'd2,
    REG_SIN  = 2'd3
  } cfg_reg_t;

  // Request kinds
  typedef enum logic {
    REQ_STORE = 1'b0,
    REQ_FETCH = 1'b1
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0]         rows;
    logic [CNT_W-1:0]         cols;
    logic signed [COEF_W-1:0] cos_coef;
    logic signed [COEF_W-1:0] sin_coef;
  } cfg_t;

  // Linear frame store address of a pixel
  function automatic logic [ADDR_W-1:0] pix_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    pix_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c));
  endfunction

endpackage

`default_nettype wire

>>> rtl/irn_frame_mem.sv
`default_nettype none

module irn_frame_mem (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [irn_pkg::ADDR_W-1:0] waddr,
  input  wire logic [irn_pkg::PIX_W-1:0]  wdata,
  input  wire logic                       re,
  input  wire logic [irn_pkg::ADDR_W-1:0] raddr,
  output logic      [irn_pkg::PIX_W-1:0]  rdata_r
);
  import irn_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];

  // Write one pixel
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; hold data when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/irn_map.sv
`default_nettype none

module irn_map (
  input  wire logic                        clk,
  input  wire logic                        start,
  input  wire logic [irn_pkg::COORD_W-1:0] row,
  input  wire logic [irn_pkg::COORD_W-1:0] col,
  input  wire irn_pkg::cfg_t               cfg,
  output logic      [irn_pkg::ADDR_W-1:0]  addr_r,
  output logic                             inside_r
);
  import irn_pkg::*;

  localparam logic signed [SUM_W:0] HALF    = (SUM_W + 1)'(1 << (FRAC - 1));
  localparam logic signed [SUM_W:0] HALF_M1 = (SUM_W + 1)'((1 << (FRAC - 1)) - 1);

  logic [CNT_W-1:0]         rows_use, cols_use, cr, cc;
  logic signed [OFS_W-1:0]  row_ext, col_ext, cr_ext, cc_ext;
  logic signed [OFS_W-1:0]  xt_r, yt_r;
  logic signed [PROD_W-1:0] p_xc_r, p_ys_r, p_yc_r, p_xs_r;
  logic signed [SUM_W-1:0]  sx, sy;
  logic signed [SUM_W:0]    sx_b, sy_b;
  logic signed [SRC_W-1:0]  xs, ys;
  logic                     inside_nxt;
  logic [ADDR_W-1:0]        addr_nxt;

  // Clamp sizes to the frame store and take the rotation center
  always_comb begin
    rows_use = (cfg.rows > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : cfg.rows;
    cols_use = (cfg.cols > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : cfg.cols;
    cr       = rows_use >> 1;
    cc       = cols_use >> 1;
    row_ext  = OFS_W'(row);
    col_ext  = OFS_W'(col);
    cr_ext   = OFS_W'(cr);
    cc_ext   = OFS_W'(cc);
  end

  // Capture offsets from the center when a fetch request enters
  always_ff @(posedge clk) begin
    if (start) begin
      xt_r <= row_ext - cr_ext;
      yt_r <= col_ext - cc_ext;
    end
  end

  // Form the four products
  always_ff @(posedge clk) begin
    p_xc_r <= xt_r * cfg.cos_coef;
    p_ys_r <= yt_r * cfg.sin_coef;
    p_yc_r <= yt_r * cfg.cos_coef;
    p_xs_r <= xt_r * cfg.sin_coef;
  end

  // Sum, round to nearest with ties away from zero, shift back by the center
  always_comb begin
    sx   = SUM_W'(p_xc_r) - SUM_W'(p_ys_r);
    sy   = SUM_W'(p_yc_r) + SUM_W'(p_xs_r);
    sx_b = (SUM_W + 1)'(sx) + (sx[SUM_W-1] ? HALF_M1 : HALF);
    sy_b = (SUM_W + 1)'(sy) + (sy[SUM_W-1] ? HALF_M1 : HALF);
    xs   = SRC_W'(sx_b >>> FRAC) + signed'(SRC_W'(cr));
    ys   = SRC_W'(sy_b >>> FRAC) + signed'(SRC_W'(cc));
    inside_nxt = !xs[SRC_W-1] && (xs < signed'(SRC_W'(rows_use))) &&
                 !ys[SRC_W-1] && (ys < signed'(SRC_W'(cols_use)));
    addr_nxt = pix_addr(xs[ROW_W-1:0], ys[COL_W-1:0]);
  end

  // Register the source address and the in-image flag
  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    inside_r <= inside_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/image_rotate_nearest.sv
// Channel   Direction  Handshake              Payload
// in_       request    in_valid / in_ready    req_type, pixel_row, pixel_col, red, green, blue
// out_      result     out_valid / out_ready  red, green, blue, source_inside
// cfg_      write      cfg_we                 cfg_index, cfg_data
//
// A store request writes the pixel at the accept edge.
// A fetch request captures its offsets at the accept edge, then holds in_ready low through
// its stages (products, rounding and address, frame store read, result load): the state
// machine admits one fetch at a time, so no new request is accepted until the result loads.
// A full result register holds the fetch in its last stage until out_ready frees it.
// The result register lets the next request enter while a result waits on out_ready.
// Reset is synchronous and clears control and configuration; the frame store is not cleared.
`default_nettype none
`include "image_rotate_nearest_macros.svh"

module image_rotate_nearest (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_req_type,
  input  wire logic [irn_pkg::COORD_W-1:0] in_pixel_row,
  input  wire logic [irn_pkg::COORD_W-1:0] in_pixel_col,
  input  wire logic [7:0]                  in_red,
  input  wire logic [7:0]                  in_green,
  input  wire logic [7:0]                  in_blue,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic                             out_source_inside,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [irn_pkg::CFG_W-1:0]   cfg_data
);
  import irn_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_ADDR,
    ST_DATA
  } state_t;

  state_t            st_r, st_nxt;
  cfg_t              cfg_r;
  logic              accept, fetch_start, mem_we, mem_re, out_load;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [PIX_W-1:0]  rdata;
  logic              map_inside;
  logic              out_valid_r, out_inside_r;
  logic [7:0]        out_red_r, out_green_r, out_blue_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows     <= CNT_W'(256);
      cfg_r.cols     <= CNT_W'(256);
      cfg_r.cos_coef <= COEF_W'(16384);
      cfg_r.sin_coef <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS: cfg_r.rows     <= cfg_data[CNT_W-1:0];
        REG_COLS: cfg_r.cols     <= cfg_data[CNT_W-1:0];
        REG_COS:  cfg_r.cos_coef <= cfg_data[COEF_W-1:0];
        REG_SIN:  cfg_r.sin_coef <= cfg_data[COEF_W-1:0];
        default:  ;
      endcase
    end
  end

  // Accept and route requests
  assign in_ready    = (st_r == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign fetch_start = accept && (in_req_type == REQ_FETCH);
  assign mem_we      = accept && (in_req_type == REQ_STORE) &&
                       (32'(in_pixel_row) < MAX_ROWS) && (32'(in_pixel_col) < MAX_COLS);
  assign waddr       = pix_addr(ROW_W'(in_pixel_row), COL_W'(in_pixel_col));
  assign mem_re      = (st_r == ST_ADDR);
  assign out_load    = (st_r == ST_DATA) && (!out_valid_r || out_ready);

  irn_map u_map (
    .clk      (clk),
    .start    (fetch_start),
    .row      (in_pixel_row),
    .col      (in_pixel_col),
    .cfg      (cfg_r),
    .addr_r   (raddr),
    .inside_r (map_inside)
  );

  irn_frame_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (waddr),
    .wdata   ({in_red, in_green, in_blue}),
    .re      (mem_re),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  // Advance a fetch through the stages; hold in ST_DATA until the result register frees
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (fetch_start) st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_SUM;
      ST_SUM:  st_nxt = ST_ADDR;
      ST_ADDR: st_nxt = ST_DATA;
      ST_DATA: if (out_load) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (out_load) begin
      out_inside_r <= map_inside;
      out_red_r    <= map_inside ? rdata[23:16] : 8'd0;
      out_green_r  <= map_inside ? rdata[15:8]  : 8'd0;
      out_blue_r   <= map_inside ? rdata[7:0]   : 8'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red           = out_red_r;
  assign out_green         = out_green_r;
  assign out_blue          = out_blue_r;
  assign out_source_inside = out_inside_r;

  `IRN_ASSERT_NEXT(a_fetch_enters, fetch_start, st_r == ST_MUL, "fetch did not enter the pipeline")
  `IRN_ASSERT_NEXT(a_result_held, (st_r == ST_DATA) && out_valid_r && !out_ready, (st_r == ST_DATA) && out_valid_r, "pending result dropped under stall")
  `IRN_ASSERT_SAME(a_outside_black, out_valid_r && !out_inside_r, (out_red_r == 8'd0) && (out_green_r == 8'd0) && (out_blue_r == 8'd0), "outside source not black")
  `IRN_ASSERT_SAME(a_no_store_in_flight, mem_we, st_r == ST_IDLE, "store during fetch")

endmodule

`default_nettype wire
